>>> sv/max_filter_3x3_core_defines.svh
// assertion macros shared by the max filter rtl
`ifndef MAX_FILTER_3X3_CORE_DEFINES_SVH
`define MAX_FILTER_3X3_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define MF3_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mf3 assertion failed");

// next-cycle implication, checked out of reset
`define MF3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mf3 assertion failed");

`else

`define MF3_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MF3_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/mf3_pkg.sv
// types, constants and helpers shared by the max filter modules
package mf3_pkg;

    localparam int MAX_SIDE    = 128;
    localparam int MIN_SIDE    = 3;
    localparam int PIXEL_BITS  = 8;
    localparam int SIDE_BITS   = 8;
    localparam int ADDR_BITS   = $clog2(MAX_SIDE);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef logic [SIDE_BITS-1:0]  t_side;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [QUEUE_AW-1:0]   t_qptr;
    typedef logic [QUEUE_AW:0]     t_qcnt;

    // one classified item: the new column of the 3-row band plus result flags
    typedef struct packed {
        t_pix pix;
        t_pix mid;
        t_pix top;
        logic emit;
        logic row_end;
        logic frame_end;
    } t_slot;

    function automatic t_pix max2(input t_pix a, input t_pix b);
        max2 = (a > b) ? a : b;
    endfunction

endpackage

>>> sv/mf3_front.sv
// front end: counters, line stores and classification of each pixel
module mf3_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  mf3_pkg::t_side i_cfg_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  mf3_pkg::t_pix i_pixel,
    output logic          o_push,
    input  logic          i_push_ready,
    output mf3_pkg::t_slot o_slot
);
    import mf3_pkg::*;

    t_pix  r_store_a [MAX_SIDE];
    t_pix  r_store_b [MAX_SIDE];

    t_side r_side;
    t_addr r_row, r_col;
    t_addr n_row, n_col;
    t_addr w_last;

    logic  r_s1_valid;
    t_pix  r_top, r_mid, r_s1_pix;
    t_addr r_s1_addr;
    logic  r_s1_emit, r_s1_row_end, r_s1_frame_end;

    logic  w_accept, w_go, w_row_end;

    assign w_last    = t_addr'(r_side - t_side'(1));
    assign w_go      = r_s1_valid && i_push_ready;
    assign o_ready   = !r_s1_valid || i_push_ready;
    assign w_accept  = i_valid && o_ready;
    assign w_row_end = (r_col == w_last);

    always_comb begin
        n_row = r_row;
        n_col = r_col + t_addr'(1);
        if (w_row_end) begin
            n_col = '0;
            n_row = (r_row == w_last) ? '0 : r_row + t_addr'(1);
        end
    end

    // side register and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= t_side'(MAX_SIDE);
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_data < t_side'(MIN_SIDE))
                r_side <= t_side'(MIN_SIDE);
            else if (i_cfg_data > t_side'(MAX_SIDE))
                r_side <= t_side'(MAX_SIDE);
            else
                r_side <= i_cfg_data;
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // line stores: read at accept, write back one stage later
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_top <= r_store_b[r_col];
            r_mid <= r_store_a[r_col];
        end
        if (w_go) begin
            r_store_b[r_s1_addr] <= r_mid;
            r_store_a[r_s1_addr] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix       <= i_pixel;
            r_s1_addr      <= r_col;
            r_s1_emit      <= (r_row >= t_addr'(2)) && (r_col >= t_addr'(2));
            r_s1_row_end   <= w_row_end;
            r_s1_frame_end <= w_row_end && (r_row == w_last);
        end
    end

    assign o_push = r_s1_valid;

    always_comb begin
        o_slot.pix       = r_s1_pix;
        o_slot.mid       = r_mid;
        o_slot.top       = r_top;
        o_slot.emit      = r_s1_emit;
        o_slot.row_end   = r_s1_row_end;
        o_slot.frame_end = r_s1_frame_end;
    end

endmodule

>>> sv/mf3_queue.sv
// short queue of classified items between front and back
`include "max_filter_3x3_core_defines.svh"
module mf3_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  mf3_pkg::t_slot i_slot,
    output logic           o_valid,
    input  logic           i_pop,
    output mf3_pkg::t_slot o_slot
);
    import mf3_pkg::*;

    t_slot r_mem [QUEUE_DEPTH];
    t_qptr r_wr, r_rd;
    t_qcnt r_count;
    logic  w_push, w_pop;

    assign o_push_ready = (r_count != t_qcnt'(QUEUE_DEPTH));
    assign o_valid      = (r_count != '0);
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_valid;
    assign o_slot       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + t_qptr'(1);
            if (w_pop)  r_rd <= r_rd + t_qptr'(1);
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + t_qcnt'(1);
                2'b01:   r_count <= r_count - t_qcnt'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `MF3_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= t_qcnt'(QUEUE_DEPTH))
    `MF3_ASSERT_NEXT(a_push_held, i_clk, i_rst_n, i_push && !o_push_ready, i_push)
    `MF3_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)

endmodule

>>> sv/mf3_back.sv
// back end: 3x3 window shift, maximum and output register
`include "max_filter_3x3_core_defines.svh"
module mf3_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_pop,
    input  mf3_pkg::t_slot i_slot,
    output logic           o_tvalid,
    input  logic           i_tready,
    output mf3_pkg::t_pix  o_tdata,
    output logic           o_tuser,
    output logic           o_tlast
);
    import mf3_pkg::*;

    t_pix r_win [6];
    logic r_out_valid;
    t_pix r_out_max;
    logic r_out_row_end, r_out_frame_end;
    logic w_free, w_pop, w_load;
    t_pix w_m0, w_m1, w_m2, w_m3, w_m4, w_m5, w_max;

    assign w_free = !r_out_valid || i_tready;
    assign w_pop  = i_valid && (!i_slot.emit || w_free);
    assign w_load = w_pop && i_slot.emit;
    assign o_pop  = w_pop;

    // balanced compare tree over the nine window pixels
    assign w_m0  = max2(r_win[0], r_win[1]);
    assign w_m1  = max2(r_win[2], r_win[3]);
    assign w_m2  = max2(r_win[4], r_win[5]);
    assign w_m3  = max2(i_slot.top, i_slot.mid);
    assign w_m4  = max2(w_m0, w_m1);
    assign w_m5  = max2(w_m2, w_m3);
    assign w_max = max2(max2(w_m4, w_m5), i_slot.pix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else if (w_pop) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= i_slot.top;
            r_win[4] <= i_slot.mid;
            r_win[5] <= i_slot.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_max       <= w_max;
            r_out_row_end   <= i_slot.row_end;
            r_out_frame_end <= i_slot.frame_end;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_max;
    assign o_tuser  = r_out_row_end;
    assign o_tlast  = r_out_frame_end;

    `MF3_ASSERT_IMPLY(a_load_has_room, i_clk, i_rst_n, w_load, w_free)
    `MF3_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && !i_tready, r_out_valid)
    `MF3_ASSERT_IMPLY(a_frame_ends_row, i_clk, i_rst_n, o_tvalid && o_tlast, o_tuser)

endmodule

>>> sv/max_filter_3x3_core.sv
// top level of the streaming 3x3 max filter over a square image
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata = pixel
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata = local_max, tuser = row_end,
//                                                      tlast = frame_end
//  cfg       in         i_cfg_we (no wait)             i_cfg_data = image_side
//
//  one pixel a cycle sustained while m_axis_tready stays high; a result passes through the line
//  store read stage, the queue and the output register
//  the line stores take one read and one write a cycle: read at accept, written a stage later
//  synchronous active-low reset clears counters, handshakes and window, side = 128
//  no clearing pass: line store entries are always written before they reach a result
//  the queue lets the front keep taking pixels while a result waits at the output
module max_filter_3x3_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: image side, clamped to 3..128, restarts the frame
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    // pixel stream in
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] pixel
    // result stream out
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] local_max
    output logic [0:0] m_axis_tuser,   // [0] row_end
    output logic       m_axis_tlast    // frame_end
);
    import mf3_pkg::*;

    // front to queue
    logic  w_push, w_push_ready;
    t_slot w_push_slot;
    // queue to back
    logic  w_q_valid, w_pop;
    t_slot w_q_slot;
    logic  w_row_end;

    // counters, line stores and classification of each item
    mf3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_pixel      (s_axis_tdata),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_slot       (w_push_slot)
    );

    // decouples front and back so each side can stall alone
    mf3_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_slot       (w_push_slot),
        .o_valid      (w_q_valid),
        .i_pop        (w_pop),
        .o_slot       (w_q_slot)
    );

    // window shift, nine-way maximum and output register
    mf3_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_pop    (w_pop),
        .i_slot   (w_q_slot),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (w_row_end),
        .o_tlast  (m_axis_tlast)
    );

    assign m_axis_tuser[0] = w_row_end;

endmodule
